### design/wef_pkg.sv
// Shared types, constants and helper functions for the wraparound emboss filter.
// Depends on nothing; every other design file imports it.
package wef_pkg;

   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned COORD_W = 8;
   localparam int unsigned SIZE_W  = 9;
   localparam int unsigned OUT_W   = 11;
   localparam int unsigned ACC_W   = 12;

   localparam logic signed [ACC_W-1:0] FULL_SCALE = 12'sd255;

   typedef enum logic {
      MODE_STORE   = 1'b0,
      MODE_COMPUTE = 1'b1
   } mode_type;

   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Read slot of a compute request on the dual-read frame store
   typedef enum logic [1:0] {
      PH_ROW_UP   = 2'd0,
      PH_ROW_MID  = 2'd1,
      PH_ROW_DOWN = 2'd2,
      PH_CENTER   = 2'd3
   } rd_phase_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // Map a size register onto the frame size in use: zero acts as one,
   // anything above the maximum acts as the maximum.
   function automatic logic [SIZE_W-1:0] used_size(logic [SIZE_W-1:0] reg_val,
                                                   int unsigned max_val);
      if (reg_val == '0) begin
         return SIZE_W'(1);
      end
      if (32'(reg_val) > max_val) begin
         return SIZE_W'(max_val);
      end
      return reg_val;
   endfunction

   // One restoring step of a remainder: shift in one dividend bit, subtract
   // the divisor when it fits.
   function automatic logic [SIZE_W-1:0] rem_step(logic [SIZE_W-1:0] rem,
                                                  logic             dbit,
                                                  logic [SIZE_W-1:0] divisor);
      logic [SIZE_W:0] trial;
      trial = {rem, dbit};
      if (trial >= {1'b0, divisor}) begin
         trial = trial - {1'b0, divisor};
      end
      return trial[SIZE_W-1:0];
   endfunction

   // Zero-extend a channel value into the signed accumulator width
   function automatic logic signed [ACC_W-1:0] widen(logic [CHAN_W-1:0] value);
      return $signed({{(ACC_W-CHAN_W){1'b0}}, value});
   endfunction

   // Clamp a sum above at full scale; the lower side stays as it is
   function automatic logic signed [OUT_W-1:0] clamp_top(logic signed [ACC_W-1:0] sum);
      if (sum > FULL_SCALE) begin
         return FULL_SCALE[OUT_W-1:0];
      end
      return sum[OUT_W-1:0];
   endfunction

endpackage

### design/wef_ifs.sv
// Handshake channel interfaces of the emboss filter: request, response and CSR write.
// Depends on wef_pkg for the payload types and widths.
interface wef_req_if;
   import wef_pkg::*;

   logic                valid;
   logic                ready;
   mode_type            mode;
   logic [COORD_W-1:0]  pix_x;
   logic [COORD_W-1:0]  pix_y;
   logic [CHAN_W-1:0]   red_in;
   logic [CHAN_W-1:0]   green_in;
   logic [CHAN_W-1:0]   blue_in;

   modport source (output valid, mode, pix_x, pix_y, red_in, green_in, blue_in,
                   input  ready);
   modport sink   (input  valid, mode, pix_x, pix_y, red_in, green_in, blue_in,
                   output ready);
endinterface

interface wef_rsp_if;
   import wef_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] red_out;
   logic signed [OUT_W-1:0] green_out;
   logic signed [OUT_W-1:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input  ready);
   modport sink   (input  valid, red_out, green_out, blue_out, output ready);
endinterface

interface wef_csr_if;
   import wef_pkg::*;

   logic               valid;
   logic               ready;
   csr_index_type      index;
   logic [SIZE_W-1:0]  data;

   modport source (output valid, index, data, input  ready);
   modport sink   (input  valid, index, data, output ready);
endinterface

### design/wraparound_emboss_filter.sv
// Wraparound emboss filter: frame store plus a pipelined 3x3 column emboss.
// Store requests are taken one per cycle while the response side does not stall
// and no compute request is issuing reads; a compute request holds off new requests
// while its seven frame store reads go through the store's two read ports.
// Reset clears all valid bits and sets both frame sizes to 256 (clamped to the
// maximum); the frame store itself is not cleared. Depends on wef_pkg, wef_ifs.
module wraparound_emboss_filter
   import wef_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = 256,
   parameter int unsigned MAX_HEIGHT = 256
) (
   input  logic          clock,
   input  logic          reset,
   wef_req_if.sink       req_ch,
   wef_rsp_if.source     rsp_ch,
   wef_csr_if.sink       csr_ch
);

   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef logic [AW-1:0]     addr_type;
   typedef logic [SIZE_W-1:0] coord_type;

   // Linear frame store address of a column and row
   function automatic addr_type pix_addr(coord_type col, coord_type row);
      logic [AW+SIZE_W-1:0] lin;
      lin = (AW+SIZE_W)'(row) * (AW+SIZE_W)'(MAX_WIDTH) + (AW+SIZE_W)'(col);
      return lin[AW-1:0];
   endfunction

   // Frame sizes in use
   coord_type w_used_ff, h_used_ff;

   // Stage 1: upper four remainder steps
   logic      s1_valid_ff;
   mode_type  s1_mode_ff;
   coord_type s1_xr_ff, s1_yr_ff;
   logic [3:0] s1_xlo_ff, s1_ylo_ff;
   pixel_type s1_pix_ff;
   coord_type s1_xr_in, s1_yr_in;

   // Stage 2: final coordinates
   logic      s2_valid_ff;
   mode_type  s2_mode_ff;
   coord_type s2_x_ff, s2_y_ff;
   pixel_type s2_pix_ff;
   coord_type s2_x_in, s2_y_in;

   // Stage 3: wrapped neighbor coordinates
   logic      s3_valid_ff;
   mode_type  s3_mode_ff;
   coord_type s3_x_ff, s3_xl_ff, s3_xr_ff, s3_y_ff, s3_yu_ff, s3_yd_ff;
   pixel_type s3_pix_ff;
   coord_type s3_xl_in, s3_xr_in, s3_yu_in, s3_yd_in;

   // Issue stage: addresses and read slot
   logic         iss_valid_ff;
   mode_type     iss_mode_ff;
   rd_phase_type iss_phase_ff, iss_phase_in;
   addr_type     iss_c_ff, iss_lu_ff, iss_lm_ff, iss_ld_ff, iss_ru_ff, iss_rm_ff, iss_rd_ff;
   pixel_type    iss_pix_ff;

   // Frame store and its registered read data
   pixel_type    frame_mem [DEPTH];
   pixel_type    rd_a_ff, rd_b_ff;
   logic         rd_valid_ff;
   rd_phase_type rd_phase_ff;
   addr_type     addr_a, addr_b;
   logic         mem_we, mem_re;

   // Accumulator
   logic signed [ACC_W-1:0] acc_red_ff, acc_green_ff, acc_blue_ff;
   logic signed [ACC_W-1:0] acc_red_in, acc_green_in, acc_blue_in;
   logic                    acc_done_ff;

   // Response register
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   // Pipeline control
   logic adv, iss_busy, front_adv;

   assign adv       = !rsp_valid_ff || rsp_ch.ready;
   assign iss_busy  = iss_valid_ff && (iss_mode_ff == MODE_COMPUTE)
                      && (iss_phase_ff != PH_CENTER);
   assign front_adv = adv && !iss_busy;
   assign mem_re    = adv && iss_valid_ff && (iss_mode_ff == MODE_COMPUTE);
   assign mem_we    = adv && iss_valid_ff && (iss_mode_ff == MODE_STORE);

   assign req_ch.ready = front_adv;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.red_out   = rsp_red_ff;
   assign rsp_ch.green_out = rsp_green_ff;
   assign rsp_ch.blue_out  = rsp_blue_ff;

   // Take frame size writes
   always_ff @(posedge clock) begin
      if (reset) begin
         w_used_ff <= used_size(SIZE_W'(256), MAX_WIDTH);
         h_used_ff <= used_size(SIZE_W'(256), MAX_HEIGHT);
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_FRAME_WIDTH:  w_used_ff <= used_size(csr_ch.data, MAX_WIDTH);
            REG_FRAME_HEIGHT: h_used_ff <= used_size(csr_ch.data, MAX_HEIGHT);
         endcase
      end
   end

   // Reduce coordinates modulo the frame size, four bits per stage
   always_comb begin
      s1_xr_in = rem_step(rem_step(rem_step(rem_step('0, req_ch.pix_x[7], w_used_ff),
                 req_ch.pix_x[6], w_used_ff), req_ch.pix_x[5], w_used_ff),
                 req_ch.pix_x[4], w_used_ff);
      s1_yr_in = rem_step(rem_step(rem_step(rem_step('0, req_ch.pix_y[7], h_used_ff),
                 req_ch.pix_y[6], h_used_ff), req_ch.pix_y[5], h_used_ff),
                 req_ch.pix_y[4], h_used_ff);
      s2_x_in  = rem_step(rem_step(rem_step(rem_step(s1_xr_ff, s1_xlo_ff[3], w_used_ff),
                 s1_xlo_ff[2], w_used_ff), s1_xlo_ff[1], w_used_ff),
                 s1_xlo_ff[0], w_used_ff);
      s2_y_in  = rem_step(rem_step(rem_step(rem_step(s1_yr_ff, s1_ylo_ff[3], h_used_ff),
                 s1_ylo_ff[2], h_used_ff), s1_ylo_ff[1], h_used_ff),
                 s1_ylo_ff[0], h_used_ff);
   end

   // Wrap neighbors at the frame edges
   always_comb begin
      s3_xl_in = (s2_x_ff == '0) ? w_used_ff - 1'b1 : s2_x_ff - 1'b1;
      s3_xr_in = (s2_x_ff == w_used_ff - 1'b1) ? '0 : s2_x_ff + 1'b1;
      s3_yu_in = (s2_y_ff == '0) ? h_used_ff - 1'b1 : s2_y_ff - 1'b1;
      s3_yd_in = (s2_y_ff == h_used_ff - 1'b1) ? '0 : s2_y_ff + 1'b1;
   end

   // Advance the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (front_adv) begin
         s1_valid_ff <= req_ch.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         s1_mode_ff <= req_ch.mode;
         s1_xr_ff   <= s1_xr_in;
         s1_yr_ff   <= s1_yr_in;
         s1_xlo_ff  <= req_ch.pix_x[3:0];
         s1_ylo_ff  <= req_ch.pix_y[3:0];
         s1_pix_ff  <= '{red: req_ch.red_in, green: req_ch.green_in, blue: req_ch.blue_in};

         s2_mode_ff <= s1_mode_ff;
         s2_x_ff    <= s2_x_in;
         s2_y_ff    <= s2_y_in;
         s2_pix_ff  <= s1_pix_ff;

         s3_mode_ff <= s2_mode_ff;
         s3_x_ff    <= s2_x_ff;
         s3_y_ff    <= s2_y_ff;
         s3_xl_ff   <= s3_xl_in;
         s3_xr_ff   <= s3_xr_in;
         s3_yu_ff   <= s3_yu_in;
         s3_yd_ff   <= s3_yd_in;
         s3_pix_ff  <= s2_pix_ff;

         iss_mode_ff <= s3_mode_ff;
         iss_pix_ff  <= s3_pix_ff;
         iss_c_ff    <= pix_addr(s3_x_ff,  s3_y_ff);
         iss_lu_ff   <= pix_addr(s3_xl_ff, s3_yu_ff);
         iss_lm_ff   <= pix_addr(s3_xl_ff, s3_y_ff);
         iss_ld_ff   <= pix_addr(s3_xl_ff, s3_yd_ff);
         iss_ru_ff   <= pix_addr(s3_xr_ff, s3_yu_ff);
         iss_rm_ff   <= pix_addr(s3_xr_ff, s3_y_ff);
         iss_rd_ff   <= pix_addr(s3_xr_ff, s3_yd_ff);
      end
   end

   // Step the read slot; a fresh request starts at the upper row
   always_comb begin
      iss_phase_in = iss_phase_ff;
      if (front_adv) begin
         iss_phase_in = PH_ROW_UP;
      end else if (adv) begin
         unique case (iss_phase_ff)
            PH_ROW_UP:   iss_phase_in = PH_ROW_MID;
            PH_ROW_MID:  iss_phase_in = PH_ROW_DOWN;
            PH_ROW_DOWN: iss_phase_in = PH_CENTER;
            default:     iss_phase_in = PH_CENTER;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
         iss_phase_ff <= PH_ROW_UP;
      end else begin
         if (front_adv) begin
            iss_valid_ff <= s3_valid_ff;
         end
         iss_phase_ff <= iss_phase_in;
      end
   end

   // Select left and right column addresses for this slot, or the center address
   always_comb begin
      unique case (iss_phase_ff)
         PH_ROW_UP:   begin addr_a = iss_lu_ff; addr_b = iss_ru_ff; end
         PH_ROW_MID:  begin addr_a = iss_lm_ff; addr_b = iss_rm_ff; end
         PH_ROW_DOWN: begin addr_a = iss_ld_ff; addr_b = iss_rd_ff; end
         default:     begin addr_a = iss_c_ff;  addr_b = iss_c_ff;  end
      endcase
   end

   // Frame store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[iss_c_ff] <= iss_pix_ff;
      end
      if (mem_re) begin
         rd_a_ff <= frame_mem[addr_a];
         rd_b_ff <= frame_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         rd_phase_ff <= PH_ROW_UP;
      end else if (adv) begin
         rd_valid_ff <= iss_valid_ff && (iss_mode_ff == MODE_COMPUTE);
         rd_phase_ff <= iss_phase_ff;
      end
   end

   // Accumulate right minus left per row, then add the center
   always_comb begin
      case (rd_phase_ff) inside
         PH_ROW_UP: begin
            acc_red_in   = widen(rd_b_ff.red)   - widen(rd_a_ff.red);
            acc_green_in = widen(rd_b_ff.green) - widen(rd_a_ff.green);
            acc_blue_in  = widen(rd_b_ff.blue)  - widen(rd_a_ff.blue);
         end
         PH_ROW_MID, PH_ROW_DOWN: begin
            acc_red_in   = acc_red_ff   + widen(rd_b_ff.red)   - widen(rd_a_ff.red);
            acc_green_in = acc_green_ff + widen(rd_b_ff.green) - widen(rd_a_ff.green);
            acc_blue_in  = acc_blue_ff  + widen(rd_b_ff.blue)  - widen(rd_a_ff.blue);
         end
         default: begin
            acc_red_in   = acc_red_ff   + widen(rd_a_ff.red);
            acc_green_in = acc_green_ff + widen(rd_a_ff.green);
            acc_blue_in  = acc_blue_ff  + widen(rd_a_ff.blue);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv && rd_valid_ff) begin
         acc_red_ff   <= acc_red_in;
         acc_green_ff <= acc_green_in;
         acc_blue_ff  <= acc_blue_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_done_ff <= 1'b0;
      end else if (adv) begin
         acc_done_ff <= rd_valid_ff && (rd_phase_ff == PH_CENTER);
      end
   end

   // Clamp and hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= acc_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_red_ff   <= clamp_top(acc_red_ff);
         rsp_green_ff <= clamp_top(acc_green_ff);
         rsp_blue_ff  <= clamp_top(acc_blue_ff);
      end
   end

`ifndef SYNTHESIS
   // A store occupies one issue slot only
   assert property (@(posedge clock) disable iff (reset)
      (iss_valid_ff && iss_mode_ff == MODE_STORE) |-> iss_phase_ff == PH_ROW_UP)
      else $error("store request left the first read slot");

   // Never write and read the frame store in the same cycle
   assert property (@(posedge clock) disable iff (reset) !(mem_we && mem_re))
      else $error("frame store write collides with a read");

   // No new request enters while a compute request still issues reads
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |-> !iss_busy)
      else $error("request accepted during compute read issue");

   // A result completes only after its center read
   assert property (@(posedge clock) disable iff (reset)
      $rose(acc_done_ff) |-> $past(rd_valid_ff && rd_phase_ff == PH_CENTER))
      else $error("accumulator finished without a center read");
`endif

endmodule

### tb/tb_wraparound_emboss_filter.sv
// Self-checking testbench for wraparound_emboss_filter: random store/compute traffic
// against an in-bench frame copy and emboss predictor, with random stalls on both sides.
// Depends on wef_pkg and the channel interfaces in wef_ifs.
module tb_wraparound_emboss_filter;
   import wef_pkg::*;

   localparam int FRAME_MAX_COLS = 256;
   localparam int FRAME_MAX_ROWS = 256;
   localparam int FRAME_CELLS    = FRAME_MAX_COLS * FRAME_MAX_ROWS;
   localparam int EMBOSS_TAPS    = 7;
   localparam int CENTER_TAP     = 0;
   localparam int FIRST_LEFT_TAP = 4;
   localparam int DRAIN_CYCLES   = 16;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic signed [OUT_W-1:0] red;
      logic signed [OUT_W-1:0] green;
      logic signed [OUT_W-1:0] blue;
   } emboss_rgb_type;

   logic clock;
   logic reset;

   wef_req_if req_ch ();
   wef_rsp_if rsp_ch ();
   wef_csr_if csr_ch ();

   wraparound_emboss_filter #(
      .MAX_WIDTH  (FRAME_MAX_COLS),
      .MAX_HEIGHT (FRAME_MAX_ROWS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Bench copy of the frame store and the size registers
   pixel_type         frame_copy [0:FRAME_CELLS-1];
   bit                was_written [0:FRAME_CELLS-1];
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;

   emboss_rgb_type pending_embossed [$];
   int             mismatch_count;
   int             requests_sent;
   bit             no_gaps;
   int             ready_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic int frame_cols();
      if (width_reg == '0) return 1;
      if (int'(width_reg) > FRAME_MAX_COLS) return FRAME_MAX_COLS;
      return int'(width_reg);
   endfunction

   function automatic int frame_rows();
      if (height_reg == '0) return 1;
      if (int'(height_reg) > FRAME_MAX_ROWS) return FRAME_MAX_ROWS;
      return int'(height_reg);
   endfunction

   // Store address of one tap: center, right column (up, mid, down), left column
   function automatic int tap_addr(int x, int y, int tap);
      int cols;
      int rows;
      int cx;
      int cy;
      int col;
      int row;
      cols = frame_cols();
      rows = frame_rows();
      cx   = x % cols;
      cy   = y % rows;
      if (tap == CENTER_TAP) begin
         col = cx;
         row = cy;
      end else begin
         col = (tap < FIRST_LEFT_TAP) ? (cx + 1) % cols : (cx + cols - 1) % cols;
         row = (cy + rows + ((tap - 1) % 3) - 1) % rows;
      end
      return row * FRAME_MAX_COLS + col;
   endfunction

   // Embossed value at (x, y) from the current frame copy
   function automatic emboss_rgb_type emboss_at(int x, int y);
      int             sum_r;
      int             sum_g;
      int             sum_b;
      int             sign;
      pixel_type      p;
      emboss_rgb_type result;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int tap = 0; tap < EMBOSS_TAPS; tap++) begin
         p     = frame_copy[tap_addr(x, y, tap)];
         sign  = (tap >= FIRST_LEFT_TAP) ? -1 : 1;
         sum_r += sign * int'(p.red);
         sum_g += sign * int'(p.green);
         sum_b += sign * int'(p.blue);
      end
      // clamp above only
      if (sum_r > 255) sum_r = 255;
      if (sum_g > 255) sum_g = 255;
      if (sum_b > 255) sum_b = 255;
      result.red   = OUT_W'(sum_r);
      result.green = OUT_W'(sum_g);
      result.blue  = OUT_W'(sum_b);
      return result;
   endfunction

   function automatic logic [CHAN_W-1:0] random_channel();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p.red   = random_channel();
      p.green = random_channel();
      p.blue  = random_channel();
      return p;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic int pick_size_reg();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 12);
      if (r < 85) return $urandom_range(13, 256);
      return $urandom_range(0, 511);
   endfunction

   // Drive one request, hold it until accepted, then update the frame copy or
   // queue the embossed result. Valid stays high for a back-to-back request.
   task automatic send_request(mode_type mode, int x, int y, pixel_type colors);
      int gap;
      int addr;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.mode     <= mode;
      req_ch.pix_x    <= COORD_W'(x);
      req_ch.pix_y    <= COORD_W'(y);
      req_ch.red_in   <= colors.red;
      req_ch.green_in <= colors.green;
      req_ch.blue_in  <= colors.blue;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      requests_sent++;
      if (mode == MODE_STORE) begin
         addr              = tap_addr(x, y, CENTER_TAP);
         frame_copy[addr]  = colors;
         was_written[addr] = 1'b1;
      end else begin
         pending_embossed.push_back(emboss_at(x, y));
      end
   endtask

   // Hold the request side until every queued result has come back
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_embossed.size() > 0) @(posedge clock);
   endtask

   task automatic wait_idle();
      drain_responses();
      // stores leave no result; let any in flight finish
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_size_reg(csr_index_type index, int value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= SIZE_W'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (index == REG_FRAME_WIDTH) begin
         width_reg = SIZE_W'(value);
      end else begin
         height_reg = SIZE_W'(value);
      end
      @(posedge clock);
   endtask

   task automatic set_frame_size(int cols_reg, int rows_reg);
      wait_idle();
      write_size_reg(REG_FRAME_WIDTH, cols_reg);
      write_size_reg(REG_FRAME_HEIGHT, rows_reg);
   endtask

   // One random step: a store anywhere, or a compute whose neighborhood is
   // first filled where never written, sometimes with a neighbor rewritten
   task automatic issue_random_item();
      int x;
      int y;
      int addr;
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 255);
      if ($urandom_range(0, 99) < 25) begin
         send_request(MODE_STORE, x, y, random_pixel());
      end else begin
         for (int tap = 0; tap < EMBOSS_TAPS; tap++) begin
            addr = tap_addr(x, y, tap);
            if (!was_written[addr]) begin
               send_request(MODE_STORE, addr % FRAME_MAX_COLS, addr / FRAME_MAX_COLS,
                            random_pixel());
            end
         end
         if ($urandom_range(0, 99) < 30) begin
            addr = tap_addr(x, y, $urandom_range(0, EMBOSS_TAPS - 1));
            send_request(MODE_STORE, addr % FRAME_MAX_COLS, addr / FRAME_MAX_COLS,
                         random_pixel());
         end
         if ($urandom_range(0, 49) == 0) begin
            drain_responses();
         end
         send_request(MODE_COMPUTE, x, y, random_pixel());
      end
   endtask

   task automatic run_frame_phase(int cols_reg, int rows_reg, int budget, bit steady);
      int start;
      set_frame_size(cols_reg, rows_reg);
      no_gaps <= steady;
      start = requests_sent;
      while (requests_sent - start < budget) issue_random_item();
   endtask

   // Reset sizes, full frame, no register written yet
   task automatic test_default_frame();
      int start;
      start = requests_sent;
      while (requests_sent - start < 100) issue_random_item();
   endtask

   // 4x3 frame: full negative swing, top clamp, corner wraps, aliased store
   task automatic test_corner_values();
      pixel_type p;
      set_frame_size(4, 3);
      for (int y = 0; y < 3; y++) begin
         for (int x = 0; x < 4; x++) begin
            p.red   = (x == 0 || x == 3) ? 8'd255 : 8'd0;
            p.green = 8'd128;
            p.blue  = CHAN_W'(40 * x + 10 * y);
            send_request(MODE_STORE, x, y, p);
         end
      end
      send_request(MODE_COMPUTE, 1, 0, p);
      send_request(MODE_COMPUTE, 3, 2, p);
      send_request(MODE_COMPUTE, 0, 0, p);
      send_request(MODE_COMPUTE, 3, 0, p);
      send_request(MODE_COMPUTE, 0, 2, p);
      send_request(MODE_COMPUTE, 2, 1, p);
      p.red   = 8'd0;
      p.green = 8'd255;
      p.blue  = 8'd255;
      send_request(MODE_STORE, 255, 254, p);
      send_request(MODE_COMPUTE, 3, 2, p);
      send_request(MODE_COMPUTE, 0, 1, p);
   endtask

   // Size registers at zero, one, the maximum and beyond it
   task automatic test_size_extremes();
      run_frame_phase(1, 1, 90, 1'b1);
      run_frame_phase(0, 0, 90, 1'b0);
      run_frame_phase(511, 511, 90, 1'b0);
      run_frame_phase(256, 1, 90, 1'b0);
      run_frame_phase(0, 256, 90, 1'b0);
   endtask

   task automatic test_random_frames();
      for (int i = 0; i < 10; i++) begin
         run_frame_phase(pick_size_reg(), pick_size_reg(), 100, (i % 4) == 0);
      end
   endtask

   // Response sink stalls: ready bursts, mostly short drops, a few long ones
   always @(posedge clock) begin
      if (no_gaps) begin
         rsp_ch.ready <= 1'b1;
         ready_hold   <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 99) < 65) begin
         rsp_ch.ready <= 1'b1;
         ready_hold   <= $urandom_range(0, 7);
      end else begin
         rsp_ch.ready <= 1'b0;
         ready_hold   <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
      end
   end

   // Compare each accepted response with the oldest expected one
   always @(posedge clock) begin : check_response
      emboss_rgb_type oldest;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_embossed.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected response: r=%0d g=%0d b=%0d",
                        rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out);
            end
         end else begin
            oldest = pending_embossed.pop_front();
            if (oldest.red !== rsp_ch.red_out || oldest.green !== rsp_ch.green_out ||
                oldest.blue !== rsp_ch.blue_out) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("response mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                           oldest.red, oldest.green, oldest.blue,
                           rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out);
               end
            end
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.mode     = MODE_STORE;
      req_ch.pix_x    = '0;
      req_ch.pix_y    = '0;
      req_ch.red_in   = '0;
      req_ch.green_in = '0;
      req_ch.blue_in  = '0;
      rsp_ch.ready    = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = REG_FRAME_WIDTH;
      csr_ch.data     = '0;
      width_reg       = SIZE_W'(256);
      height_reg      = SIZE_W'(256);
      mismatch_count  = 0;
      requests_sent   = 0;
      no_gaps         = 1'b0;
      ready_hold      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_frame();
      test_corner_values();
      test_size_extremes();
      test_random_frames();

      wait_idle();
      if (mismatch_count == 0 && pending_embossed.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
